@@ rtl/bkrd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bkrd_pkg
// types, constants and codes shared by the boot keyboard report differ
// ----------------------------------------------------------------------------
package bkrd_pkg;

    localparam int NUM_SLOTS       = 4;
    localparam int SLOT_W          = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int KEYS_PER_REPORT = 6;
    localparam int NUM_EVENTS      = 2 * KEYS_PER_REPORT;

    localparam logic [6:0] BOOT_REPORT_LEN = 7'd8;
    localparam logic [7:0] ERR_CODE_LOW    = 8'd1;
    localparam logic [7:0] ERR_CODE_HIGH   = 8'd3;

    typedef enum logic [1:0] {
        CMD_REPORT  = 2'd0,
        CMD_MOUNT   = 2'd1,
        CMD_UNMOUNT = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] interface_index;
        logic [6:0] device_address;
        logic       is_keyboard;
        logic [6:0] report_length;
        logic [7:0] modifier_bits;
        logic [7:0] key_0;
        logic [7:0] key_1;
        logic [7:0] key_2;
        logic [7:0] key_3;
        logic [7:0] key_4;
        logic [7:0] key_5;
    } in_item_t;

    typedef struct packed {
        logic [7:0] key_code;
        logic [7:0] modifiers_now;
        logic       pressed;
        logic       last_event;
    } out_item_t;

    typedef logic [KEYS_PER_REPORT-1:0][7:0] keys_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic pending;
        logic final_one;
    } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/bkrd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bkrd_if
// valid/ready channels for input items and key event items
// ----------------------------------------------------------------------------
interface bkrd_in_if;
    import bkrd_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bkrd_out_if;
    import bkrd_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/bkrd_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bkrd_datapath
// slot table, report compare, event mask and output payload register
// ----------------------------------------------------------------------------
module bkrd_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bkrd_pkg::dp_cmd_t    ctl,
    output bkrd_pkg::dp_status_t      status,
    input  wire bkrd_pkg::in_item_t   in_item,
    output bkrd_pkg::out_item_t       out_item
);
    import bkrd_pkg::*;

    logic [NUM_SLOTS-1:0] in_use_reg;
    logic [6:0]           dev_reg  [NUM_SLOTS];
    keys_t                keys_reg [NUM_SLOTS];

    in_item_t              item_reg;
    keys_t                 old_reg;
    logic [NUM_EVENTS-1:0] mask_reg;
    logic [NUM_EVENTS-1:0] mask_next;
    out_item_t             out_reg;
    out_item_t             out_next;

    logic [SLOT_W-1:0]     slot;
    logic                  idx_ok;
    logic                  dev_match;
    logic                  key_err;
    logic                  report_ok;
    keys_t                 now_keys;
    keys_t                 old_keys;
    logic [NUM_EVENTS-1:0] low_bit;
    logic [7:0]            sel_key;

    assign slot      = SLOT_W'(item_reg.interface_index);
    assign idx_ok    = int'(item_reg.interface_index) < NUM_SLOTS;
    assign dev_match = in_use_reg[slot] && (dev_reg[slot] == item_reg.device_address);
    assign old_keys  = keys_reg[slot];
    assign now_keys  = {item_reg.key_5, item_reg.key_4, item_reg.key_3,
                        item_reg.key_2, item_reg.key_1, item_reg.key_0};

    // press bits first in key order, then release bits
    always_comb
    begin
        logic held;
        key_err   = 1'b0;
        mask_next = '0;
        for (int i = 0; i < KEYS_PER_REPORT; i++)
        begin
            if (now_keys[i] >= ERR_CODE_LOW && now_keys[i] <= ERR_CODE_HIGH)
            begin
                key_err = 1'b1;
            end
            held = 1'b0;
            for (int j = 0; j < KEYS_PER_REPORT; j++)
            begin
                if (old_keys[j] == now_keys[i])
                begin
                    held = 1'b1;
                end
            end
            mask_next[i] = (now_keys[i] != 8'd0) && !held;
            held = 1'b0;
            for (int j = 0; j < KEYS_PER_REPORT; j++)
            begin
                if (now_keys[j] == old_keys[i])
                begin
                    held = 1'b1;
                end
            end
            mask_next[KEYS_PER_REPORT + i] = (old_keys[i] != 8'd0) && !held;
        end
        report_ok = idx_ok && (item_reg.cmd == CMD_REPORT)
                    && (item_reg.report_length >= BOOT_REPORT_LEN)
                    && dev_match && !key_err;
        if (!report_ok)
        begin
            mask_next = '0;
        end
    end

    // lowest pending event
    assign low_bit = mask_reg & (~mask_reg + NUM_EVENTS'(1));

    always_comb
    begin
        sel_key = 8'd0;
        for (int i = 0; i < KEYS_PER_REPORT; i++)
        begin
            if (low_bit[i])
            begin
                sel_key = sel_key | now_keys[i];
            end
            if (low_bit[KEYS_PER_REPORT + i])
            begin
                sel_key = sel_key | old_reg[i];
            end
        end
        out_next.key_code      = sel_key;
        out_next.modifiers_now = item_reg.modifier_bits;
        out_next.pressed       = |low_bit[KEYS_PER_REPORT-1:0];
        out_next.last_event    = (mask_reg & ~low_bit) == '0;
    end

    assign status.pending   = |mask_reg;
    assign status.final_one = (mask_reg & ~low_bit) == '0;
    assign out_item         = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
            mask_reg   <= '0;
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                dev_reg[s]  <= '0;
                keys_reg[s] <= '0;
            end
        end
        else
        begin
            if (ctl.eval)
            begin
                mask_reg <= mask_next;
                if (idx_ok)
                begin
                    case (item_reg.cmd)
                        CMD_MOUNT:
                        begin
                            if (item_reg.is_keyboard)
                            begin
                                in_use_reg[slot] <= 1'b1;
                                dev_reg[slot]    <= item_reg.device_address;
                                keys_reg[slot]   <= '0;
                            end
                            else
                            begin
                                in_use_reg[slot] <= 1'b0;
                            end
                        end
                        CMD_UNMOUNT:
                        begin
                            if (dev_match)
                            begin
                                in_use_reg[slot] <= 1'b0;
                            end
                        end
                        CMD_REPORT:
                        begin
                            if (report_ok)
                            begin
                                keys_reg[slot] <= now_keys;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            else if (ctl.emit)
            begin
                mask_reg <= mask_reg & ~low_bit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            item_reg <= in_item;
        end
        if (ctl.eval)
        begin
            old_reg <= old_keys;
        end
        if (ctl.emit)
        begin
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/bkrd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bkrd_ctrl
// sequencer for item intake, slot evaluation and event emission
// ----------------------------------------------------------------------------
module bkrd_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output bkrd_pkg::dp_cmd_t          ctl,
    input  wire bkrd_pkg::dp_status_t  status
);
    import bkrd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                ctl.eval   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.pending)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    ctl.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.final_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/boot_keyboard_report_differ.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// boot_keyboard_report_differ
// turns boot keyboard reports into single press and release event items
// ----------------------------------------------------------------------------
// the first event item is registered in the emit state, after the eval state for the input item
// sequence: each item passes the idle, eval and emit states, also with no event;
//   the emit step of the sequencer sends one event per cycle while the output is free
// a waiting output item does not block intake of the next input item
// reset: all slots free, device addresses and stored keys cleared at once
module boot_keyboard_report_differ (
    input wire logic  clk,
    input wire logic  rst_n,
    bkrd_in_if.sink   upstream,
    bkrd_out_if.source downstream
);
    import bkrd_pkg::*;

    dp_cmd_t    ctl;
    dp_status_t status;
    logic       in_ready;
    logic       out_valid;
    out_item_t  out_item;

    bkrd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (upstream.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (downstream.ready),
        .ctl       (ctl),
        .status    (status)
    );

    bkrd_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .status   (status),
        .in_item  (upstream.payload),
        .out_item (out_item)
    );

    assign upstream.ready     = in_ready;
    assign downstream.valid   = out_valid;
    assign downstream.payload = out_item;

endmodule
`default_nettype wire
